// ----- design/bidi_run_visual_reorder_defines.svh -----
// ----------------------------------------------------------------------------
// Bidi run visual reorder assertion macros
// Concurrent assertion wrappers shared by the reorder RTL, empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef BIDI_RUN_VISUAL_REORDER_DEFINES_SVH
`define BIDI_RUN_VISUAL_REORDER_DEFINES_SVH

`ifndef SYNTH
// Condition must hold at every clock edge outside reset.
`define BRVR_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);
// Consequent must hold in the same cycle as the antecedent.
`define BRVR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define BRVR_ASSERT(lbl, cond, msg)
`define BRVR_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

// ----- design/brvr_pkg.sv -----
// ----------------------------------------------------------------------------
// Bidi run visual reorder package
// Field widths and sequencer state type shared by the reorder RTL.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brvr_pkg;

  localparam int unsigned LEVEL_W = 7;
  localparam int unsigned START_W = 12;
  localparam int unsigned VIS_W   = 13;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT,
    S_LV0_RD,
    S_LV0,
    S_NEXT,
    S_NEXT_WT,
    S_ADV,
    S_WALK,
    S_WALK_O,
    S_WALK_L,
    S_DECIDE,
    S_REV,
    S_REV_A,
    S_REV_B,
    S_REV_C,
    S_CHK,
    S_EMIT_RD,
    S_EMIT_WT
  } state_e;

endpackage

// ----- design/brvr_ifs.sv -----
// ----------------------------------------------------------------------------
// Bidi run visual reorder channel interfaces
// Valid/ready channels for run items in and visual indices out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface brvr_in_if import brvr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic [START_W-1:0] start_index;
  logic               is_last;

  modport source (output valid, level, start_index, is_last, input ready);
  modport sink   (input valid, level, start_index, is_last, output ready);
endinterface

interface brvr_out_if import brvr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VIS_W-1:0] visual_index;
  logic             end_of_order;

  modport source (output valid, visual_index, end_of_order, input ready);
  modport sink   (input valid, visual_index, end_of_order, output ready);
endinterface

// ----- design/bidi_run_visual_reorder.sv -----
// ----------------------------------------------------------------------------
// Bidi run visual reorder
// Collects the levels of a line's runs and emits the runs in visual order.
// ----------------------------------------------------------------------------
// A run item is taken while the block is idle; items that are not last give
// no result. The last item starts the reordering, during which the block is
// not ready: it sets up the order table, scans the runs, walks back and swaps
// pairs of order entries, and emits the indices. For N runs in the line the
// work is quadratic in N in the worst case, bounded by the single read and
// write port of the order memory, which every walk and swap goes through.
// Output back-pressure stalls emission without loss.
`timescale 1ns / 1ps

`include "bidi_run_visual_reorder_defines.svh"

module bidi_run_visual_reorder import brvr_pkg::*; #(
  parameter int unsigned MAX_SPANS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  brvr_in_if.sink     in_i,
  brvr_out_if.source  out_o
);

  localparam int unsigned AW = $clog2(MAX_SPANS);
  localparam int unsigned CW = $clog2(MAX_SPANS + 1);

  state_e             state_q, state_d;
  logic [CW-1:0]      run_cnt_q, run_cnt_d;
  logic [START_W-1:0] base_q, base_d;
  logic [LEVEL_W-1:0] cur_q, cur_d;
  logic [LEVEL_W-1:0] next_q, next_d;
  logic [LEVEL_W-1:0] prev_q, prev_d;
  logic [AW-1:0]      ss_q, ss_d;
  logic [CW-1:0]      end_q, end_d;
  logic [AW-1:0]      lo_q, lo_d;
  logic [CW-1:0]      hi_q, hi_d;
  logic [AW-1:0]      tmp_q, tmp_d;
  logic [CW-1:0]      k_q, k_d;
  logic               out_valid_q, out_valid_d;
  logic [VIS_W-1:0]   out_index_q, out_index_d;
  logic               out_eoo_q, out_eoo_d;

  logic               lvl_we, lvl_re;
  logic [AW-1:0]      lvl_waddr, lvl_raddr;
  logic [LEVEL_W-1:0] lvl_wdata, lvl_rdata;
  logic               ord_we, ord_re;
  logic [AW-1:0]      ord_waddr, ord_raddr;
  logic [AW-1:0]      ord_wdata, ord_rdata;

  logic               in_acc;
  logic               out_free;
  logic [CW-1:0]      k_inc;
  logic [CW-1:0]      hi_dec;
  logic [LEVEL_W-1:0] nl;
  logic [LEVEL_W-1:0] d1, d2, dmin;
  logic               rev_odd;
  logic               can_swap;

  brvr_ram #(.WIDTH(LEVEL_W), .DEPTH(MAX_SPANS)) u_level_ram (
    .clk_i   (clk_i),
    .we_i    (lvl_we),
    .waddr_i (lvl_waddr),
    .wdata_i (lvl_wdata),
    .re_i    (lvl_re),
    .raddr_i (lvl_raddr),
    .rdata_o (lvl_rdata)
  );

  brvr_ram #(.WIDTH(AW), .DEPTH(MAX_SPANS)) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .re_i    (ord_re),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  assign in_acc   = in_i.valid && (state_q == S_IDLE);
  assign out_free = !out_valid_q || out_o.ready;
  assign k_inc    = k_q + CW'(1);
  assign hi_dec   = hi_q - CW'(1);

  // Past the last run the following level counts as zero.
  assign nl = (end_q < run_cnt_q) ? lvl_rdata : '0;

  assign d1       = cur_q - next_q;
  assign d2       = cur_q - prev_q;
  assign dmin     = (d1 < d2) ? d1 : d2;
  assign rev_odd  = dmin[0];
  assign can_swap = (CW'(lo_q) + CW'(1)) < hi_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && in_i.is_last) begin
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        if (k_inc == run_cnt_q) begin
          state_d = (run_cnt_q <= CW'(1)) ? S_EMIT_RD : S_LV0_RD;
        end
      end
      S_LV0_RD:  state_d = S_LV0;
      S_LV0:     state_d = S_NEXT;
      S_NEXT:    state_d = S_NEXT_WT;
      S_NEXT_WT: state_d = (cur_q <= nl) ? S_ADV : S_WALK;
      S_ADV:     state_d = (end_q == run_cnt_q) ? S_EMIT_RD : S_NEXT;
      S_WALK:    state_d = (ss_q == '0) ? S_DECIDE : S_WALK_O;
      S_WALK_O:  state_d = S_WALK_L;
      S_WALK_L:  state_d = (lvl_rdata < cur_q) ? S_DECIDE : S_WALK;
      S_DECIDE:  state_d = rev_odd ? S_REV : S_CHK;
      S_REV:     state_d = can_swap ? S_REV_A : S_CHK;
      S_REV_A:   state_d = S_REV_B;
      S_REV_B:   state_d = S_REV_C;
      S_REV_C:   state_d = S_REV;
      S_CHK:     state_d = (cur_q > next_q) ? S_WALK : S_ADV;
      S_EMIT_RD: state_d = S_EMIT_WT;
      S_EMIT_WT: begin
        if (out_free) begin
          state_d = (k_inc == run_cnt_q) ? S_IDLE : S_EMIT_RD;
        end
      end
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath updates and memory controls.
  always_comb begin
    run_cnt_d   = run_cnt_q;
    base_d      = base_q;
    cur_d       = cur_q;
    next_d      = next_q;
    prev_d      = prev_q;
    ss_d        = ss_q;
    end_d       = end_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    tmp_d       = tmp_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_index_d = out_index_q;
    out_eoo_d   = out_eoo_q;
    lvl_we      = 1'b0;
    lvl_waddr   = '0;
    lvl_wdata   = '0;
    lvl_re      = 1'b0;
    lvl_raddr   = '0;
    ord_we      = 1'b0;
    ord_waddr   = '0;
    ord_wdata   = '0;
    ord_re      = 1'b0;
    ord_raddr   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (run_cnt_q == '0) begin
            base_d = in_i.start_index;
          end
          // Runs past the store depth are dropped but is_last still counts.
          if (run_cnt_q < CW'(MAX_SPANS)) begin
            lvl_we    = 1'b1;
            lvl_waddr = run_cnt_q[AW-1:0];
            lvl_wdata = in_i.level;
            run_cnt_d = run_cnt_q + CW'(1);
          end
          k_d = '0;
        end
      end
      S_INIT: begin
        ord_we    = 1'b1;
        ord_waddr = k_q[AW-1:0];
        ord_wdata = k_q[AW-1:0];
        k_d       = (k_inc == run_cnt_q) ? '0 : k_inc;
      end
      S_LV0_RD: begin
        lvl_re = 1'b1;
      end
      S_LV0: begin
        cur_d = lvl_rdata;
        ss_d  = '0;
        end_d = CW'(1);
      end
      S_NEXT: begin
        if (end_q < run_cnt_q) begin
          lvl_re    = 1'b1;
          lvl_raddr = end_q[AW-1:0];
        end
      end
      S_NEXT_WT: begin
        next_d = nl;
        if (cur_q < nl) begin
          cur_d = nl;
          ss_d  = end_q[AW-1:0];
        end
      end
      S_ADV: begin
        if (end_q != run_cnt_q) begin
          end_d = end_q + CW'(1);
        end
      end
      S_WALK: begin
        if (ss_q == '0) begin
          prev_d = '0;
        end else begin
          ss_d      = ss_q - AW'(1);
          ord_re    = 1'b1;
          ord_raddr = ss_q - AW'(1);
        end
      end
      S_WALK_O: begin
        // Levels are looked up through the current visual order.
        lvl_re    = 1'b1;
        lvl_raddr = ord_rdata;
      end
      S_WALK_L: begin
        if (lvl_rdata < cur_q) begin
          prev_d = lvl_rdata;
          ss_d   = ss_q + AW'(1);
        end
      end
      S_DECIDE: begin
        lo_d  = ss_q;
        hi_d  = end_q;
        cur_d = (prev_q > next_q) ? prev_q : next_q;
      end
      S_REV: begin
        if (can_swap) begin
          ord_re    = 1'b1;
          ord_raddr = lo_q;
        end
      end
      S_REV_A: begin
        tmp_d     = ord_rdata;
        ord_re    = 1'b1;
        ord_raddr = hi_dec[AW-1:0];
      end
      S_REV_B: begin
        ord_we    = 1'b1;
        ord_waddr = lo_q;
        ord_wdata = ord_rdata;
      end
      S_REV_C: begin
        ord_we    = 1'b1;
        ord_waddr = hi_dec[AW-1:0];
        ord_wdata = tmp_q;
        lo_d      = lo_q + AW'(1);
        hi_d      = hi_dec;
      end
      S_CHK: begin
      end
      S_EMIT_RD: begin
        ord_re    = 1'b1;
        ord_raddr = k_q[AW-1:0];
      end
      S_EMIT_WT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_index_d = VIS_W'(base_q) + VIS_W'(ord_rdata);
          out_eoo_d   = (k_inc == run_cnt_q);
          if (k_inc == run_cnt_q) begin
            run_cnt_d = '0;
            k_d       = '0;
          end else begin
            k_d = k_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_cnt_q   <= '0;
      base_q      <= '0;
      cur_q       <= '0;
      next_q      <= '0;
      prev_q      <= '0;
      ss_q        <= '0;
      end_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      tmp_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      out_index_q <= '0;
      out_eoo_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_cnt_q   <= run_cnt_d;
      base_q      <= base_d;
      cur_q       <= cur_d;
      next_q      <= next_d;
      prev_q      <= prev_d;
      ss_q        <= ss_d;
      end_q       <= end_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      tmp_q       <= tmp_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      out_index_q <= out_index_d;
      out_eoo_q   <= out_eoo_d;
    end
  end

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.visual_index = out_index_q;
  assign out_o.end_of_order = out_eoo_q;

  `BRVR_ASSERT(a_run_cnt_bound, run_cnt_q <= CW'(MAX_SPANS), "run count beyond store depth")
  `BRVR_ASSERT_IMPL(a_walk_after_drop, state_q == S_WALK, cur_q > next_q, "walk without a level drop")
  `BRVR_ASSERT_IMPL(a_walk_below_end, state_q == S_WALK_L, CW'(ss_q) < end_q, "walk left its stretch")
  `BRVR_ASSERT_IMPL(a_swap_in_range, state_q == S_REV_A, can_swap, "swap outside its stretch")
  `BRVR_ASSERT_IMPL(a_emit_in_range, state_q == S_EMIT_RD, k_q < run_cnt_q, "emit index past run count")

endmodule

// ----- design/brvr_ram.sv -----
// ----------------------------------------------------------------------------
// Bidi run visual reorder generic RAM
// One write port and one read port with a registered read that holds its data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brvr_ram #(
  parameter int unsigned WIDTH = 7,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
